// ----- src/dpr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared constants, types and the CORDIC arctangent table for the
// distance phase rotator.
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int PHASE_BITS   = 16;

  // CORDIC setup
  localparam int CORDIC_ITERS    = 24;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
  localparam int ITER_IDX_W      = $clog2(CORDIC_ITERS);

  // Datapath widths: prescaled sample is Q.30, plus headroom for CORDIC gain
  localparam int XY_WIDTH    = SAMPLE_WIDTH + 32;
  localparam int ANGLE_WIDTH = 32;
  localparam int FRAC_SHIFT  = 30;

  localparam logic [31:0] INV_WAVELENGTH_RESET = 32'd134310674;
  // 1/K in Q0.30, K = CORDIC gain
  localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;

  typedef logic signed [XY_WIDTH-1:0]    xy_t;
  typedef logic signed [ANGLE_WIDTH-1:0] zres_t;
  typedef logic [ANGLE_WIDTH-1:0]        angle_t;

  // atan(2^-i) in turns, 2^32 = one turn
  function automatic logic [31:0] atan_turn(input logic [ITER_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/distance_phase_rotator_unit.sv -----
// ----------------------------------------------------------------------------
// distance_phase_rotator_unit
// Rotates a complex sample by a phase taken from distance * inv_wavelength
// or given directly in turns; CORDIC rotation, rounded and saturated output.
// ----------------------------------------------------------------------------
// Pipeline: done_o follows the accepted beat through the input reg,
//   phase/prescale multiply, quarter-turn fold, 12 CORDIC stages of two
//   micro-rotations and the round/saturate register.
// Throughput: one beat per clock; busy_o is always low since every stage
//   advances each cycle and the receiver cannot stall.
// Reset: valid bits clear, inv_wavelength returns to 134310674.
// ----------------------------------------------------------------------------
module distance_phase_rotator_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [31:0]                            cfg_wdata_i,
  // command side
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   func_i,
  input  logic signed [dpr_pkg::SAMPLE_WIDTH-1:0] sample_re_i,
  input  logic signed [dpr_pkg::SAMPLE_WIDTH-1:0] sample_im_i,
  input  logic [31:0]                            distance_i,
  input  logic [15:0]                            phase_turns_i,
  // result side
  output logic                                   done_o,
  output logic signed [dpr_pkg::SAMPLE_WIDTH-1:0] rot_re_o,
  output logic signed [dpr_pkg::SAMPLE_WIDTH-1:0] rot_im_o,
  output logic                                   overflow_o
);

  localparam int SW  = dpr_pkg::SAMPLE_WIDTH;
  localparam int XW  = dpr_pkg::XY_WIDTH;
  localparam int PB  = dpr_pkg::PHASE_BITS;
  localparam int AW  = dpr_pkg::ANGLE_WIDTH;
  localparam int FSH = dpr_pkg::FRAC_SHIFT;

  // Pipeline never stalls: a beat can enter every cycle.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [31:0] inv_wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_wl_q <= dpr_pkg::INV_WAVELENGTH_RESET;
    end else if (cfg_we_i) begin
      inv_wl_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the command beat
  // --------------------------------------------------------------------------
  logic                 s1_vld_q;
  logic                 s1_func_q;
  logic signed [SW-1:0] s1_re_q, s1_im_q;
  logic [31:0]          s1_dist_q;
  logic [15:0]          s1_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_func_q  <= func_i;
    s1_re_q    <= sample_re_i;
    s1_im_q    <= sample_im_i;
    s1_dist_q  <= distance_i;
    s1_phase_q <= phase_turns_i;
  end

  // --------------------------------------------------------------------------
  // Stage 2: phase from distance (32x32 multiply, keep fractional turns),
  // prescale both sample parts by 1/K.
  // --------------------------------------------------------------------------
  logic [63:0]  prod;
  logic [AW-1:0] angle_raw, angle_d;
  dpr_pkg::xy_t x2_d, y2_d;

  logic          s2_vld_q;
  dpr_pkg::angle_t s2_angle_q;
  dpr_pkg::xy_t  s2_x_q, s2_y_q;

  always_comb begin
    prod = 64'(s1_dist_q) * 64'(inv_wl_q);
    // product is Q24.40; bits 39..8 are the fractional turn as a 32-bit angle
    angle_raw = s1_func_q ? {s1_phase_q, 16'h0000} : prod[39:8];
    // quantize to the top PHASE_BITS bits
    angle_d = {angle_raw[AW-1 -: PB], {(AW-PB){1'b0}}};
    x2_d = XW'(s1_re_q) * XW'(dpr_pkg::KINV_Q30);
    y2_d = XW'(s1_im_q) * XW'(dpr_pkg::KINV_Q30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_angle_q <= angle_d;
    s2_x_q     <= x2_d;
    s2_y_q     <= y2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: fold to nearest quarter turn, residual in [-1/8, 1/8) turn
  // --------------------------------------------------------------------------
  logic [AW-1:0]  angle_rnd;
  logic [1:0]     quad;
  dpr_pkg::zres_t z3_d;
  dpr_pkg::xy_t   x3_d, y3_d;

  logic           s3_vld_q;
  dpr_pkg::xy_t   s3_x_q, s3_y_q;
  dpr_pkg::zres_t s3_z_q;

  always_comb begin
    angle_rnd = s2_angle_q + 32'h2000_0000;
    quad      = angle_rnd[AW-1 -: 2];
    z3_d      = $signed(s2_angle_q - {quad, {(AW-2){1'b0}}});
    case (quad)
      2'd0: begin
        x3_d = s2_x_q;
        y3_d = s2_y_q;
      end
      2'd1: begin
        x3_d = -s2_y_q;
        y3_d = s2_x_q;
      end
      2'd2: begin
        x3_d = -s2_x_q;
        y3_d = -s2_y_q;
      end
      2'd3: begin
        x3_d = s2_y_q;
        y3_d = -s2_x_q;
      end
      default: begin
        x3_d = s2_x_q;
        y3_d = s2_y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_x_q <= x3_d;
    s3_y_q <= y3_d;
    s3_z_q <= z3_d;
  end

  // --------------------------------------------------------------------------
  // CORDIC core
  // --------------------------------------------------------------------------
  logic         cd_vld;
  dpr_pkg::xy_t cd_x, cd_y;

  dpr_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_vld_q),
    .in_x_i      (s3_x_q),
    .in_y_i      (s3_y_q),
    .in_z_i      (s3_z_q),
    .out_valid_o (cd_vld),
    .out_x_o     (cd_x),
    .out_y_o     (cd_y)
  );

  // --------------------------------------------------------------------------
  // Output stage: divide by 2^30 rounding half up, saturate to SW bits
  // --------------------------------------------------------------------------
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);
  localparam logic signed [XW-1:0] RND_HALF = XW'(64'sd1 <<< (FSH - 1));

  dpr_pkg::xy_t         xr, yr;
  logic signed [SW-1:0] re_d, im_d;
  logic                 ovf_d;

  always_comb begin
    xr    = (cd_x + RND_HALF) >>> FSH;
    yr    = (cd_y + RND_HALF) >>> FSH;
    ovf_d = 1'b0;
    if (xr > SAT_HI) begin
      re_d  = SAT_HI[SW-1:0];
      ovf_d = 1'b1;
    end else if (xr < SAT_LO) begin
      re_d  = SAT_LO[SW-1:0];
      ovf_d = 1'b1;
    end else begin
      re_d = xr[SW-1:0];
    end
    if (yr > SAT_HI) begin
      im_d  = SAT_HI[SW-1:0];
      ovf_d = 1'b1;
    end else if (yr < SAT_LO) begin
      im_d  = SAT_LO[SW-1:0];
      ovf_d = 1'b1;
    end else begin
      im_d = yr[SW-1:0];
    end
  end

  logic                 done_q;
  logic signed [SW-1:0] rot_re_q, rot_im_q;
  logic                 ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_re_q <= re_d;
    rot_im_q <= im_d;
    ovf_q    <= ovf_d;
  end

  assign done_o     = done_q;
  assign rot_re_o   = rot_re_q;
  assign rot_im_o   = rot_im_q;
  assign overflow_o = ovf_q;

endmodule

// ----- src/dpr_cordic.sv -----
// ----------------------------------------------------------------------------
// dpr_cordic
// Pipelined rotation-mode CORDIC, two micro-rotations per register stage.
// ----------------------------------------------------------------------------
module dpr_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  dpr_pkg::xy_t   in_x_i,
  input  dpr_pkg::xy_t   in_y_i,
  input  dpr_pkg::zres_t in_z_i,
  output logic           out_valid_o,
  output dpr_pkg::xy_t   out_x_o,
  output dpr_pkg::xy_t   out_y_o
);

  localparam int NS  = dpr_pkg::CORDIC_STAGES;
  localparam int IPS = dpr_pkg::ITERS_PER_STAGE;

  logic           vld_q [NS];
  dpr_pkg::xy_t   x_q   [NS];
  dpr_pkg::xy_t   y_q   [NS];
  dpr_pkg::zres_t z_q   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic           vld_in;
    dpr_pkg::xy_t   x_in, y_in, x_d, y_d;
    dpr_pkg::zres_t z_in, z_d;

    if (s == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign x_in   = in_x_i;
      assign y_in   = in_y_i;
      assign z_in   = in_z_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign x_in   = x_q[s-1];
      assign y_in   = y_q[s-1];
      assign z_in   = z_q[s-1];
    end

    always_comb begin
      dpr_pkg::xy_t   xt, yt, xs, ys;
      dpr_pkg::zres_t zt, at;
      xt = x_in;
      yt = y_in;
      zt = z_in;
      for (int k = 0; k < IPS; k++) begin
        xs = xt >>> (s * IPS + k);
        ys = yt >>> (s * IPS + k);
        at = $signed(dpr_pkg::atan_turn(dpr_pkg::ITER_IDX_W'(s * IPS + k)));
        if (zt >= 0) begin
          xt = xt - ys;
          yt = yt + xs;
          zt = zt - at;
        end else begin
          xt = xt + ys;
          yt = yt - xs;
          zt = zt + at;
        end
      end
      x_d = xt;
      y_d = yt;
      z_d = zt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s] <= x_d;
      y_q[s] <= y_d;
      z_q[s] <= z_d;
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_x_o     = x_q[NS-1];
  assign out_y_o     = y_q[NS-1];

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for distance_phase_rotator_unit: a bit-true predictor
// of the phase derivation, quarter-turn fold, CORDIC and round/saturate
// stage is checked against every strobed beat under several wavelengths.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpr_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  // depth of the accept-to-done path, plus a little slack
  localparam int PIPE_DEPTH = 20;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // operand select on func_i
  typedef enum logic {
    ROT_BY_DISTANCE = 1'b0,
    ROT_BY_PHASE    = 1'b1
  } rot_src_e;

  typedef struct {
    rot_src_e             func;
    logic signed [SW-1:0] sample_re;
    logic signed [SW-1:0] sample_im;
    logic [31:0]          distance;
    logic [15:0]          phase_turns;
  } cmd_t;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 overflow;
  } rot_result_t;

  // atan(2^-i) in turns, 2^32 = one turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [31:0]          cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic                 func_i;
  logic signed [SW-1:0] sample_re_i;
  logic signed [SW-1:0] sample_im_i;
  logic [31:0]          distance_i;
  logic [15:0]          phase_turns_i;
  logic                 done_o;
  logic signed [SW-1:0] rot_re_o;
  logic signed [SW-1:0] rot_im_o;
  logic                 overflow_o;

  distance_phase_rotator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .sample_re_i  (sample_re_i),
    .sample_im_i  (sample_im_i),
    .distance_i   (distance_i),
    .phase_turns_i(phase_turns_i),
    .done_o       (done_o),
    .rot_re_o     (rot_re_o),
    .rot_im_o     (rot_im_o),
    .overflow_o   (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting to be driven, and rotations predicted for beats already
  // accepted but not yet strobed back.
  cmd_t        cmd_pending_q[$];
  rot_result_t rot_expected_q[$];

  // local copy of the one register
  logic [31:0] inv_wl_model = INV_WAVELENGTH_RESET;

  int err_count   = 0;
  int n_accepted  = 0;
  int n_by_dist   = 0;
  int n_by_phase  = 0;
  int n_results   = 0;
  int n_saturated = 0;
  int n_settings  = 0;

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic signed [SW-1:0] clamp_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SW-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SW-1:0];
    return v[SW-1:0];
  endfunction

  // Bit-true rotation of one command under inv_wavelength wl.
  function automatic rot_result_t rotate_sample(input cmd_t c, input logic [31:0] wl);
    logic [63:0] prod;
    logic [31:0] angle;
    logic [31:0] biased;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      x, y, xs, ys, z, tmp, rx, ry;
    rot_result_t res;

    // Distance product is Q24.40; the fractional turn is bits 39..8.
    if (c.func == ROT_BY_DISTANCE) begin
      prod  = 64'(c.distance) * 64'(wl);
      angle = prod[39:8];
    end else begin
      angle = {c.phase_turns, 16'd0};
    end
    angle = angle & ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    x = longint'(c.sample_re) * longint'(KINV_Q30);
    y = longint'(c.sample_im) * longint'(KINV_Q30);

    // nearest quarter turn, residual in [-1/8, 1/8)
    biased = angle + 32'h2000_0000;
    quad   = biased[31:30];
    resid  = angle - {quad, 30'd0};
    z      = longint'($signed(resid));

    case (quad)
      2'd1: begin
        tmp = x; x = -y; y = tmp;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        tmp = x; x = y; y = -tmp;
      end
      default: ;
    endcase

    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TURNS[i]);
      end
    end

    // round half up out of Q.30, then clip
    rx = (x + (longint'(1) <<< 29)) >>> 30;
    ry = (y + (longint'(1) <<< 29)) >>> 30;
    res.re       = clamp_sample(rx);
    res.im       = clamp_sample(ry);
    res.overflow = (rx > SAMPLE_MAX) || (rx < SAMPLE_MIN) ||
                   (ry > SAMPLE_MAX) || (ry < SAMPLE_MIN);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of back-to-back beats separated by random gaps; now and
  // then it holds off until every predicted rotation has come back.
  // --------------------------------------------------------------------------
  cmd_t cur_cmd;
  int   burst_left = 1;
  int   gap_left   = 0;
  bit   drain_hold = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i       <= 1'b0;
      func_i        <= ROT_BY_DISTANCE;
      sample_re_i   <= '0;
      sample_im_i   <= '0;
      distance_i    <= '0;
      phase_turns_i <= '0;
    end else begin
      // beat presented during the cycle just ended was taken
      if (start_i && !busy_o) begin
        rot_expected_q.push_back(rotate_sample(cur_cmd, inv_wl_model));
        n_accepted++;
        if (cur_cmd.func == ROT_BY_DISTANCE) n_by_dist++;
        else n_by_phase++;
      end
      // a stalled beat stays on the ports untouched
      if (!start_i || !busy_o) begin
        if (drain_hold && rot_expected_q.size() == 0) drain_hold = 1'b0;
        if (drain_hold || gap_left > 0) begin
          if (!drain_hold) gap_left--;
          start_i <= 1'b0;
        end else if (cmd_pending_q.size() > 0) begin
          cur_cmd       = cmd_pending_q.pop_front();
          func_i        <= cur_cmd.func;
          sample_re_i   <= cur_cmd.sample_re;
          sample_im_i   <= cur_cmd.sample_im;
          distance_i    <= cur_cmd.distance;
          phase_turns_i <= cur_cmd.phase_turns;
          start_i       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // long stretches with no idling mixed with short choppy bursts
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            drain_hold = ($urandom_range(0, 11) == 0);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: done_o marks a one-cycle result beat. Sampled mid-cycle so the
  // driver's push at the accepting edge is never racing the compare.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rot_result_t want;
    if (rst_ni && done_o !== 1'b0) begin
      n_results++;
      if (overflow_o === 1'b1) n_saturated++;
      if (rot_expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: re %0d im %0d",
                                  rot_re_o, rot_im_o));
      end else begin
        want = rot_expected_q.pop_front();
        if (rot_re_o !== want.re || rot_im_o !== want.im ||
            overflow_o !== want.overflow)
          report_mismatch($sformatf(
            "beat %0d: re %0d/%0d im %0d/%0d ovf %b/%b (got/exp)", n_results,
            rot_re_o, want.re, rot_im_o, want.im, overflow_o, want.overflow));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cmd(input rot_src_e f, input int re, input int im,
                          input logic [31:0] dist_m, input logic [15:0] ph);
    cmd_t c;
    c.func        = f;
    c.sample_re   = re[SW-1:0];
    c.sample_im   = im[SW-1:0];
    c.distance    = dist_m;
    c.phase_turns = ph;
    cmd_pending_q.push_back(c);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN[SW-1:0];
      1:       return SAMPLE_MAX[SW-1:0];
      2:       return SW'($urandom_range(0, 6)) - SW'(3);
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic push_random_cmd();
    rot_src_e         f;
    logic [31:0]      dist_m;
    logic [15:0]      ph;
    f = rot_src_e'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       dist_m = $urandom_range(0, 65535);
      1:       dist_m = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: dist_m = $urandom();
    endcase
    // a quarter of phases sit on or within two LSBs of an eighth-turn fold boundary
    if ($urandom_range(0, 3) == 0)
      ph = 16'h2000 + 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
    else
      ph = 16'($urandom());
    push_cmd(f, pick_sample(), pick_sample(), dist_m, ph);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_pending_q.size() != 0 || start_i || rot_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Register writes only land with the pipe empty.
  task automatic write_inv_wavelength(input logic [31:0] wl);
    repeat (2) @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= wl;
    inv_wl_model = wl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_setting(input bit do_write, input logic [31:0] wl, input int n_rand);
    wait_idle();
    if (do_write) write_inv_wavelength(wl);
    @(negedge clk_i);
    n_settings++;
    repeat (n_rand) push_random_cmd();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed corners under the reset wavelength, then random
  // traffic across a sweep of wavelengths including both extremes.
  // --------------------------------------------------------------------------
  initial begin
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // quarter turns and their neighbors, full-scale corners
    push_cmd(ROT_BY_PHASE, 32767, 0, 32'd0, 16'h0000);
    push_cmd(ROT_BY_PHASE, 32767, -32768, 32'd0, 16'h4000);
    push_cmd(ROT_BY_PHASE, -32768, -32768, 32'd0, 16'h8000);
    push_cmd(ROT_BY_PHASE, -32768, 32767, 32'd0, 16'hC000);
    push_cmd(ROT_BY_PHASE, 32767, 32767, 32'd0, 16'hFFFF);
    push_cmd(ROT_BY_PHASE, 0, -32768, 32'd0, 16'h3FFF);
    push_cmd(ROT_BY_PHASE, 0, 0, 32'd0, 16'h0001);
    // eighth-turn fold boundary: full-scale corner saturates here
    push_cmd(ROT_BY_PHASE, 32767, 32767, 32'd0, 16'h2000);
    push_cmd(ROT_BY_PHASE, -32768, -32768, 32'd0, 16'h1FFF);
    push_cmd(ROT_BY_PHASE, -32768, 32767, 32'd0, 16'h6000);
    push_cmd(ROT_BY_PHASE, 1, -1, 32'd0, 16'hE000);
    push_cmd(ROT_BY_PHASE, -32768, 0, 32'd0, 16'hA000);
    // distance mode at zero, one LSB, one meter and full range
    push_cmd(ROT_BY_DISTANCE, 12345, -23456, 32'd0, 16'h5A5A);
    push_cmd(ROT_BY_DISTANCE, 32767, 0, 32'd1, 16'h0000);
    push_cmd(ROT_BY_DISTANCE, -1, -1, 32'h0001_0000, 16'hFFFF);
    push_cmd(ROT_BY_DISTANCE, 32767, -32768, 32'hFFFF_FFFF, 16'h0000);
    // the operand not selected must be ignored
    push_cmd(ROT_BY_DISTANCE, 32767, 32767, 32'h1234_5678, 16'h2000);
    push_cmd(ROT_BY_PHASE, 20000, -20000, 32'hFFFF_FFFF, 16'h8000);
    push_cmd(ROT_BY_PHASE, -20000, 20000, 32'h0000_0000, 16'h8000);

    run_setting(1'b0, INV_WAVELENGTH_RESET, 140);
    run_setting(1'b1, 32'h0000_0000, 140);
    run_setting(1'b1, 32'hFFFF_FFFF, 140);
    run_setting(1'b1, 32'h0000_0001, 140);
    run_setting(1'b1, 32'h0100_0000, 140);
    run_setting(1'b1, $urandom(), 140);
    run_setting(1'b1, 32'h8000_0000, 140);
    run_setting(1'b1, INV_WAVELENGTH_RESET, 130);
    run_setting(1'b1, $urandom(), 130);

    // drain, then a quiet stretch to catch stray strobes
    wait_idle();
    repeat (PIPE_DEPTH * 2) @(posedge clk_i);
    if (rot_expected_q.size() != 0)
      report_mismatch($sformatf("%0d rotations never came back", rot_expected_q.size()));

    $display("Covered %0d beats (%0d by distance, %0d by phase) over %0d wavelength settings,",
             n_accepted, n_by_dist, n_by_phase, n_settings);
    $display("%0d result beats checked, %0d of them saturated; %0d errors.",
             n_results, n_saturated, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
src/dpr_pkg.sv
src/dpr_cordic.sv
src/distance_phase_rotator_unit.sv
verif/tb.sv
